[sv/pcx_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the PCX line pixel decoder.
// No dependencies; every other file of the block imports this package.
package pcx_pkg;

    localparam int LINE_BYTES_MAX  = 1024;
    localparam int PLANES_MAX      = 4;
    localparam int PALETTE_ENTRIES = 256;
    localparam int WIDTH_MAX       = 8192;

    localparam int ADDR_W  = $clog2(LINE_BYTES_MAX);
    localparam int PLANE_W = $clog2(PLANES_MAX);
    localparam int PAL_W   = $clog2(PALETTE_ENTRIES);

    typedef enum logic [1:0] {
        REQ_PALETTE = 2'd0,
        REQ_BYTE    = 2'd1,
        REQ_PIXEL   = 2'd2,
        REQ_NONE    = 2'd3
    } pcx_req_t;

    typedef enum logic [2:0] {
        ST_PIXEL     = 3'd0,
        ST_NOT_READY = 3'd1,
        ST_HELD      = 3'd2,
        ST_ZERO_RUN  = 3'd3,
        ST_FRAME     = 3'd4
    } pcx_status_t;

    localparam logic [2:0] MODE_1BPP  = 3'd0;
    localparam logic [2:0] MODE_2BPP  = 3'd1;
    localparam logic [2:0] MODE_4BPP  = 3'd2;
    localparam logic [2:0] MODE_24BPP = 3'd4;

    localparam logic [2:0] REG_PIXEL_MODE   = 3'd0;
    localparam logic [2:0] REG_PLANE_COUNT  = 3'd1;
    localparam logic [2:0] REG_LINE_BYTES   = 3'd2;
    localparam logic [2:0] REG_LINE_WIDTH   = 3'd3;
    localparam logic [2:0] REG_FRAME_HEIGHT = 3'd4;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  palette_index;
        logic [23:0] palette_rgb;
        logic [7:0]  data_byte;
    } pcx_in_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_in_line;
        logic       last_in_frame;
    } pcx_out_t;

    typedef struct packed {
        logic [2:0]  pixel_mode;
        logic [2:0]  plane_count;
        logic [10:0] plane_bytes;
        logic [13:0] line_width;
        logic [16:0] frame_height;
    } pcx_cfg_t;

    // Write into the line store.
    typedef struct packed {
        logic               we;
        logic [PLANE_W-1:0] plane;
        logic [ADDR_W-1:0]  addr;
        logic [7:0]         data;
    } pcx_wr_t;

    // Result descriptor handed from the control unit to the pixel pipeline.
    typedef struct packed {
        logic       valid;
        logic [2:0] status;
        logic       last_line;
        logic       last_frame;
        logic [2:0] sub;
        logic       oob;
    } pcx_res_t;

    function automatic logic [2:0] pcx_eff_planes(input logic [2:0] pc);
        return (pc == 3'd0) ? 3'd1 : pc;
    endfunction

    function automatic logic [2:0] pcx_kept(input logic [2:0] mode, input logic [2:0] pc);
        logic [2:0] p;
        logic [2:0] lim;
        p   = pcx_eff_planes(pc);
        lim = 3'd1;
        if (mode == MODE_1BPP) begin
            lim = 3'(PLANES_MAX);
        end else if (mode == MODE_24BPP) begin
            lim = 3'd3;
        end
        return (p < lim) ? p : lim;
    endfunction

endpackage

[sv/pcx_lstore.sv]
`timescale 1ns / 1ps
// Line store: one synchronous byte memory per plane, one write and one read port.
// Depends on pcx_pkg.
module pcx_lstore (
    input  logic                                   aclk,
    input  pcx_pkg::pcx_wr_t                       wr,
    input  logic                                   rd_en,
    input  logic [pcx_pkg::ADDR_W-1:0]             rd_addr,
    output logic [pcx_pkg::PLANES_MAX-1:0][7:0]    rd_data
);
    import pcx_pkg::*;

    for (genvar k = 0; k < PLANES_MAX; k++) begin : g_bank
        logic [7:0] bank_mem [LINE_BYTES_MAX];

        always_ff @(posedge aclk) begin
            if (wr.we && (wr.plane == PLANE_W'(k))) begin
                bank_mem[wr.addr] <= wr.data;
            end
        end

        always_ff @(posedge aclk) begin
            if (rd_en) begin
                rd_data[k] <= bank_mem[rd_addr];
            end
        end
    end

endmodule

[sv/pcx_pal.sv]
`timescale 1ns / 1ps
// Colour table: synchronous RGB memory with one write and one registered read port.
// Depends on pcx_pkg.
module pcx_pal (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [pcx_pkg::PAL_W-1:0]  wr_addr,
    input  logic [23:0]                wr_data,
    input  logic                       rd_en,
    input  logic [pcx_pkg::PAL_W-1:0]  rd_addr,
    output logic [23:0]                rd_data
);
    import pcx_pkg::*;

    logic [23:0] pal_mem [PALETTE_ENTRIES];

    always_ff @(posedge aclk) begin
        if (we) begin
            pal_mem[wr_addr] <= wr_data;
        end
    end

    // A read in the same cycle as a write to the same entry returns the old entry.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= pal_mem[rd_addr];
        end
    end

endmodule

[sv/pcx_ctrl.sv]
`timescale 1ns / 1ps
// Control unit: request decode, run expansion, line fill and pixel/row counters.
// Depends on pcx_pkg.
module pcx_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  pcx_pkg::pcx_cfg_t            cfg,
    input  logic                         s_valid,
    input  pcx_pkg::pcx_in_t             s_data,
    input  logic                         adv,
    output logic                         s_ready,
    output pcx_pkg::pcx_wr_t             wr,
    output logic [pcx_pkg::ADDR_W-1:0]   rd_addr,
    output pcx_pkg::pcx_res_t            res
);
    import pcx_pkg::*;

    logic [2:0]  fill_plane_reg, fill_plane_next;
    logic [10:0] fill_pos_reg, fill_pos_next;
    logic        run_pending_reg, run_pending_next;
    logic [5:0]  run_length_reg, run_length_next;
    logic        line_ready_reg, line_ready_next;
    logic [12:0] pix_pos_reg, pix_pos_next;
    logic [16:0] row_reg, row_next;
    logic        error_reg, error_next;
    logic [5:0]  rem_reg, rem_next;
    logic [7:0]  byte_reg, byte_next;

    logic [2:0]  eff_planes, kept;
    logic [10:0] eff_lb;
    logic [13:0] eff_w;
    logic [16:0] eff_h;
    logic        busy, acc, frame_done, do_put, line_done, start_run;
    logic [7:0]  put_data;
    logic [11:0] pos_inc;
    logic [3:0]  plane_inc;
    logic [13:0] pix_inc;
    logic [17:0] row_inc;
    logic [12:0] idx;

    assign eff_planes = pcx_eff_planes(cfg.plane_count);
    assign kept       = pcx_kept(cfg.pixel_mode, cfg.plane_count);
    assign eff_lb     = (cfg.plane_bytes == 11'd0) ? 11'd1 :
                        (cfg.plane_bytes > 11'(LINE_BYTES_MAX)) ? 11'(LINE_BYTES_MAX) :
                        cfg.plane_bytes;
    assign eff_w      = (cfg.line_width == 14'd0) ? 14'd1 :
                        (cfg.line_width > 14'(WIDTH_MAX)) ? 14'(WIDTH_MAX) : cfg.line_width;
    assign eff_h      = (cfg.frame_height == 17'd0) ? 17'd1 : cfg.frame_height;

    assign busy       = (rem_reg != 6'd0);
    assign s_ready    = adv && !busy;
    assign acc        = s_valid && s_ready;
    assign frame_done = (row_reg >= eff_h);
    assign pos_inc    = {1'b0, fill_pos_reg} + 12'd1;
    assign plane_inc  = {1'b0, fill_plane_reg} + 4'd1;
    assign pix_inc    = {1'b0, pix_pos_reg} + 14'd1;
    assign row_inc    = {1'b0, row_reg} + 18'd1;

    always_comb begin
        unique case (cfg.pixel_mode)
            MODE_1BPP: idx = {3'd0, pix_pos_reg[12:3]};
            MODE_2BPP: idx = {2'd0, pix_pos_reg[12:2]};
            MODE_4BPP: idx = {1'd0, pix_pos_reg[12:1]};
            default:   idx = pix_pos_reg;
        endcase
    end
    assign rd_addr = idx[ADDR_W-1:0];

    always_comb begin
        fill_plane_next  = fill_plane_reg;
        fill_pos_next    = fill_pos_reg;
        run_pending_next = run_pending_reg;
        run_length_next  = run_length_reg;
        line_ready_next  = line_ready_reg;
        pix_pos_next     = pix_pos_reg;
        row_next         = row_reg;
        error_next       = error_reg;
        rem_next         = rem_reg;
        byte_next        = byte_reg;
        do_put           = 1'b0;
        put_data         = byte_reg;
        line_done        = 1'b0;
        start_run        = 1'b0;
        res              = '0;
        res.sub          = pix_pos_reg[2:0];
        res.oob          = ({1'b0, idx} >= {3'd0, eff_lb});
        wr               = '0;

        if (busy) begin
            do_put = 1'b1;
        end else if (acc) begin
            if (s_data.req_type == REQ_BYTE || s_data.req_type == REQ_PIXEL) begin
                res.valid = 1'b1;
                if (error_reg) begin
                    res.status = ST_ZERO_RUN;
                end else if (frame_done) begin
                    res.status = ST_FRAME;
                end else if (s_data.req_type == REQ_BYTE) begin
                    res.valid = 1'b0;
                    if (line_ready_reg) begin
                        res.valid  = 1'b1;
                        res.status = ST_HELD;
                    end else if (run_pending_reg) begin
                        run_pending_next = 1'b0;
                        do_put           = 1'b1;
                        put_data         = s_data.data_byte;
                        byte_next        = s_data.data_byte;
                        start_run        = 1'b1;
                    end else if (s_data.data_byte[7:6] == 2'b11) begin
                        if (s_data.data_byte[5:0] == 6'd0) begin
                            error_next = 1'b1;
                            res.valid  = 1'b1;
                            res.status = ST_ZERO_RUN;
                        end else begin
                            run_pending_next = 1'b1;
                            run_length_next  = s_data.data_byte[5:0];
                        end
                    end else begin
                        do_put   = 1'b1;
                        put_data = s_data.data_byte;
                    end
                end else if (!line_ready_reg) begin
                    res.status = ST_NOT_READY;
                end else begin
                    res.status = ST_PIXEL;
                    if (pix_inc >= eff_w) begin
                        res.last_line   = 1'b1;
                        res.last_frame  = (row_inc >= {1'b0, eff_h});
                        line_ready_next = 1'b0;
                        pix_pos_next    = '0;
                        row_next        = row_inc[16:0];
                    end else begin
                        pix_pos_next = pix_inc[12:0];
                    end
                end
            end
        end

        if (do_put) begin
            wr.we    = (fill_plane_reg < kept) && (fill_pos_reg < 11'(LINE_BYTES_MAX));
            wr.plane = fill_plane_reg[PLANE_W-1:0];
            wr.addr  = fill_pos_reg[ADDR_W-1:0];
            wr.data  = put_data;
            fill_pos_next = pos_inc[10:0];
            if (pos_inc >= {1'b0, eff_lb}) begin
                fill_pos_next   = '0;
                fill_plane_next = plane_inc[2:0];
                if (plane_inc >= {1'b0, eff_planes}) begin
                    fill_plane_next = '0;
                    line_ready_next = 1'b1;
                    pix_pos_next    = '0;
                    line_done       = 1'b1;
                end
            end
        end

        if (busy) begin
            rem_next = (line_done || rem_reg == 6'd1) ? 6'd0 : rem_reg - 6'd1;
        end else if (start_run) begin
            rem_next = line_done ? 6'd0 : run_length_reg - 6'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_plane_reg  <= '0;
            fill_pos_reg    <= '0;
            run_pending_reg <= 1'b0;
            run_length_reg  <= '0;
            line_ready_reg  <= 1'b0;
            pix_pos_reg     <= '0;
            row_reg         <= '0;
            error_reg       <= 1'b0;
            rem_reg         <= '0;
        end else begin
            fill_plane_reg  <= fill_plane_next;
            fill_pos_reg    <= fill_pos_next;
            run_pending_reg <= run_pending_next;
            run_length_reg  <= run_length_next;
            line_ready_reg  <= line_ready_next;
            pix_pos_reg     <= pix_pos_next;
            row_reg         <= row_next;
            error_reg       <= error_next;
            rem_reg         <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

    // The zero-run error is sticky until reset.
    a_error_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        error_reg |=> error_reg)
        else $error("error flag cleared without reset");

    // A held line is only released by an accepted pixel request.
    a_line_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (line_ready_reg && !(acc && s_data.req_type == REQ_PIXEL)) |=> line_ready_reg)
        else $error("line released without a pixel request");

    // Run expansion never runs while a complete line is held.
    a_run_no_line: assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> !line_ready_reg)
        else $error("run expanding into a held line");

endmodule

[sv/pcx_rle_line_pixel_decoder.sv]
`timescale 1ns / 1ps
// PCX run-length line decoder with palette and RGB pixel delivery; top level.
// Pipeline: two register stages, p1_reg and p2_reg; a result is offered on the m_ channel
// once it has passed through both. Throughput: one transaction per cycle while the output
// slot is free or taken; the data byte of a run holds s_ready low until the rest of the run
// is written (sooner when the line ends first), one store write per cycle.
// Reset: aresetn is synchronous, active low; memories hold undefined data until written.
module pcx_rle_line_pixel_decoder (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pcx_pkg::pcx_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output pcx_pkg::pcx_out_t m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [16:0]       cfg_data
);
    import pcx_pkg::*;

    // Configuration registers are always writable; the user writes them only while
    // the block is idle.
    pcx_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pixel_mode   <= 3'd3;
            cfg_reg.plane_count  <= 3'd1;
            cfg_reg.plane_bytes  <= 11'd1;
            cfg_reg.line_width   <= 14'd1;
            cfg_reg.frame_height <= 17'd1;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_PIXEL_MODE:   cfg_reg.pixel_mode   <= cfg_data[2:0];
                REG_PLANE_COUNT:  cfg_reg.plane_count  <= cfg_data[2:0];
                REG_LINE_BYTES:   cfg_reg.plane_bytes  <= cfg_data[10:0];
                REG_LINE_WIDTH:   cfg_reg.line_width   <= cfg_data[13:0];
                REG_FRAME_HEIGHT: cfg_reg.frame_height <= cfg_data;
                default: ;
            endcase
        end
    end

    // The whole result pipeline moves forward when the output slot is free or taken.
    logic adv;
    assign adv = !m_valid || m_ready;

    pcx_wr_t                     wr;
    logic [ADDR_W-1:0]           rd_addr;
    pcx_res_t                    res;
    logic [PLANES_MAX-1:0][7:0]  bank_q;

    pcx_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_valid (s_valid),
        .s_data  (s_data),
        .adv     (adv),
        .s_ready (s_ready),
        .wr      (wr),
        .rd_addr (rd_addr),
        .res     (res)
    );

    // Stage one: the line store read happens together with the control decision.
    pcx_lstore u_lstore (
        .aclk    (aclk),
        .wr      (wr),
        .rd_en   (adv),
        .rd_addr (rd_addr),
        .rd_data (bank_q)
    );

    pcx_res_t p1_reg, p2_reg;
    logic     p2_direct_reg;
    logic [23:0] p2_rgb_reg;

    // Stage two: unpack the pixel from the plane bytes and look up the palette.
    logic [2:0]                 kept;
    logic [PLANES_MAX-1:0][7:0] b;
    logic [2:0]                 sh;
    logic [7:0]                 sh2;
    logic [PAL_W-1:0]           pidx;
    logic                       direct;
    logic [23:0]                direct_rgb;
    logic [23:0]                pal_q;

    assign kept = pcx_kept(cfg_reg.pixel_mode, cfg_reg.plane_count);
    assign sh   = 3'd7 - p1_reg.sub;
    assign sh2  = b[0] >> {~p1_reg.sub[1:0], 1'b0};

    always_comb begin
        for (int k = 0; k < PLANES_MAX; k++) begin
            b[k] = ((k < int'(kept)) && !p1_reg.oob) ? bank_q[k] : 8'd0;
        end
    end

    always_comb begin
        pidx       = '0;
        direct     = 1'b0;
        direct_rgb = {b[0], b[1], b[2]};
        unique case (cfg_reg.pixel_mode)
            MODE_1BPP: begin
                for (int k = 0; k < PLANES_MAX; k++) begin
                    pidx[k] = b[k][sh];
                end
            end
            MODE_2BPP:  pidx = PAL_W'(sh2[1:0]);
            MODE_4BPP:  pidx = PAL_W'(p1_reg.sub[0] ? b[0][3:0] : b[0][7:4]);
            MODE_24BPP: direct = 1'b1;
            default:    pidx = PAL_W'(b[0]);
        endcase
    end

    pcx_pal u_pal (
        .aclk    (aclk),
        .we      (s_valid && s_ready && s_data.req_type == REQ_PALETTE),
        .wr_addr (s_data.palette_index[PAL_W-1:0]),
        .wr_data (s_data.palette_rgb),
        .rd_en   (adv),
        .rd_addr (pidx),
        .rd_data (pal_q)
    );

    // Reset clears only the valid bits; the rest of each stage is loaded when it moves.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_reg.valid <= 1'b0;
            p2_reg.valid <= 1'b0;
        end else if (adv) begin
            p1_reg        <= res;
            p2_reg        <= p1_reg;
            p2_direct_reg <= direct;
            p2_rgb_reg    <= direct_rgb;
        end
    end

    // Stage three: the output slot. Non-pixel statuses carry an all-zero payload.
    logic        pix_ok;
    logic [23:0] out_rgb;

    assign pix_ok  = (p2_reg.status == ST_PIXEL);
    assign out_rgb = pix_ok ? (p2_direct_reg ? p2_rgb_reg : pal_q) : 24'd0;
    assign m_valid = p2_reg.valid;

    always_comb begin
        m_data.status        = p2_reg.status;
        m_data.red           = out_rgb[23:16];
        m_data.green         = out_rgb[15:8];
        m_data.blue          = out_rgb[7:0];
        m_data.last_in_line  = pix_ok && p2_reg.last_line;
        m_data.last_in_frame = pix_ok && p2_reg.last_frame;
    end

endmodule
